// ===== hw/rtl/sda_pkg.sv =====
`timescale 1ns / 1ps

package sda_pkg;

    localparam int NUM_SECTORS = 6;
    localparam int SECTOR_W    = 3;
    localparam int DIST_W      = 16;
    localparam int RAD_W       = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_READ,
        ST_WAIT,
        ST_UPDATE,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

    // 30-degree bin of the vector (u, v), 0..11; the origin maps to bin 6.
    function automatic logic [3:0] bin30(input logic signed [16:0] u,
                                         input logic signed [16:0] v);
        logic [1:0]  q;
        logic [16:0] a;
        logic [16:0] b;
        logic [35:0] aa;
        logic [35:0] bb;
        logic [1:0]  sub;
        q = 2'd3;
        a = 17'(-v);
        b = 17'(u);
        if (u > 0 && v >= 0)
        begin
            q = 2'd0; a = 17'(u);  b = 17'(v);
        end
        else if (u <= 0 && v > 0)
        begin
            q = 2'd1; a = 17'(v);  b = 17'(-u);
        end
        else if (u < 0 && v <= 0)
        begin
            q = 2'd2; a = 17'(-u); b = 17'(-v);
        end
        aa = 36'(a) * 36'(a);
        bb = 36'(b) * 36'(b);
        if (3 * bb < aa)
            sub = 2'd0;
        else if (bb < 3 * aa)
            sub = 2'd1;
        else
            sub = 2'd2;
        if (u == 0 && v == 0)
            bin30 = 4'd6;
        else
            bin30 = 4'(3 * q + sub);
    endfunction

endpackage

// ===== hw/rtl/sda_divider.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module sda_divider #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    import sda_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, denom})
            begin
                rem_next     = trial - {1'b0, denom};
                quot_next[0] = 1'b1;
            end
            else
                rem_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = busy_reg && (cnt_reg == CNT_W'(1));
    assign quot = quot_next;
endmodule

// ===== hw/rtl/sector_distance_averager_unit.sv =====
`timescale 1ns / 1ps
// Points are taken one at a time; in_stall stays high after a transaction while the square
// root resolves one root bit a cycle and the window updates.
// A final point adds six means in order 0 to 5, each through a divider start, the SUM_W-bit
// division and output, which out_stall can hold.
// rst_n is asynchronous, active low: pattern mode, counts, sums and pointers clear.
// The distance ring memory is not cleared; the fill count guards its reads.
module sector_distance_averager_unit #(
    parameter int WINDOW_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [15:0]                  point_x,
    input  logic signed [15:0]                  point_y,
    input  logic                                last_in_frame,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sda_pkg::SECTOR_W-1:0]        sector,
    output logic [sda_pkg::DIST_W-1:0]          mean_distance,
    output logic                                sector_empty,
    output logic                                last_sector,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data
);
    import sda_pkg::*;

    localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = DIST_W + CNT_W;
    localparam int ADDR_W = $clog2(NUM_SECTORS * WINDOW_DEPTH);

    state_t state_reg, state_next;

    logic                mode_reg;
    logic [SUM_W-1:0]    sum_reg   [NUM_SECTORS];
    logic [CNT_W-1:0]    count_reg [NUM_SECTORS];
    logic [PTR_W-1:0]    wp_reg    [NUM_SECTORS];
    logic [DIST_W-1:0]   ring      [NUM_SECTORS * WINDOW_DEPTH];
    logic [DIST_W-1:0]   old_reg;

    logic [DIST_W-1:0]   root_reg;
    logic [3:0]          step_reg;
    logic [SECTOR_W-1:0] sec_reg;
    logic                last_reg;
    logic [SECTOR_W-1:0] k_reg;
    logic [DIST_W-1:0]   mean_reg;

    logic [3:0]          bin;
    logic [SECTOR_W-1:0] sec_calc;
    logic [ADDR_W-1:0]   addr;
    logic [DIST_W+2:0]   trial;
    logic                full;
    logic                div_done;
    logic [SUM_W-1:0]    quot;
    logic                div_start;

    // root iteration: remainder in rem_reg, radicand bits shifted out of the top
    logic [RAD_W-1:0]    radicand_reg;
    logic [DIST_W+1:0]   rem_reg;

    assign bin      = bin30(-17'(point_y), 17'(point_x));
    // offset pattern: bin 0 wraps to the last sector
    assign sec_calc = mode_reg ? ((bin == 4'd0) ? SECTOR_W'(NUM_SECTORS - 1)
                                                : SECTOR_W'((bin - 4'd1) >> 1))
                               : SECTOR_W'(bin >> 1);
    assign addr     = ADDR_W'(sec_reg * WINDOW_DEPTH + wp_reg[sec_reg]);
    assign full     = (count_reg[sec_reg] == CNT_W'(WINDOW_DEPTH));
    assign trial    = {rem_reg[DIST_W:0], radicand_reg[RAD_W-1 -: 2]}
                      - {1'b0, root_reg, 2'b01};
    assign div_start = (state_reg == ST_DIV_START);

    sda_divider #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .numer(sum_reg[k_reg]),
        .denom(count_reg[k_reg]),
        .done (div_done),
        .quot (quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_ROOT;
            ST_ROOT:      if (step_reg == 4'd15) state_next = ST_READ;
            ST_READ:      state_next = ST_WAIT;
            ST_WAIT:      state_next = ST_UPDATE;
            ST_UPDATE:    state_next = last_reg ? ST_DIV_START : ST_IDLE;
            ST_DIV_START: state_next = ST_DIV_RUN;
            ST_DIV_RUN:   if (div_done) state_next = ST_EMIT;
            ST_EMIT:
                if (!out_stall)
                    state_next = (k_reg == SECTOR_W'(NUM_SECTORS - 1)) ? ST_IDLE
                                                                       : ST_DIV_START;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = (state_reg != ST_IDLE);
        cfg_ready     = (state_reg == ST_IDLE);
        out_valid     = (state_reg == ST_EMIT);
        sector        = k_reg;
        mean_distance = mean_reg;
        sector_empty  = (count_reg[k_reg] == '0);
        last_sector   = (k_reg == SECTOR_W'(NUM_SECTORS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
            k_reg     <= '0;
            step_reg  <= '0;
            for (int i = 0; i < NUM_SECTORS; i++)
            begin
                sum_reg[i]   <= '0;
                count_reg[i] <= '0;
                wp_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                mode_reg <= cfg_data;
            if (state_reg == ST_IDLE)
                step_reg <= '0;
            else if (state_reg == ST_ROOT)
                step_reg <= step_reg + 1'b1;
            if (state_reg == ST_UPDATE)
            begin
                k_reg <= '0;
                if (full)
                    sum_reg[sec_reg] <= sum_reg[sec_reg] - SUM_W'(old_reg)
                                        + SUM_W'(root_reg);
                else
                begin
                    sum_reg[sec_reg]   <= sum_reg[sec_reg] + SUM_W'(root_reg);
                    count_reg[sec_reg] <= count_reg[sec_reg] + 1'b1;
                end
                wp_reg[sec_reg] <= (wp_reg[sec_reg] == PTR_W'(WINDOW_DEPTH - 1))
                                   ? '0 : wp_reg[sec_reg] + 1'b1;
            end
            if (state_reg == ST_EMIT && !out_stall)
            begin
                if (k_reg == SECTOR_W'(NUM_SECTORS - 1))
                begin
                    k_reg <= '0;
                    for (int i = 0; i < NUM_SECTORS; i++)
                    begin
                        sum_reg[i]   <= '0;
                        count_reg[i] <= '0;
                        wp_reg[i]    <= '0;
                    end
                end
                else
                    k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            radicand_reg <= 32'(point_x) * 32'(point_x) + 32'(point_y) * 32'(point_y);
            rem_reg      <= '0;
            root_reg     <= '0;
            sec_reg      <= sec_calc;
            last_reg     <= last_in_frame;
        end
        else if (state_reg == ST_ROOT)
        begin
            // one result bit per step from the top radicand pair
            radicand_reg <= {radicand_reg[RAD_W-3:0], 2'b00};
            if (!trial[DIST_W+2])
            begin
                rem_reg  <= trial[DIST_W+1:0];
                root_reg <= {root_reg[DIST_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[DIST_W-1:0], radicand_reg[RAD_W-1 -: 2]};
                root_reg <= {root_reg[DIST_W-2:0], 1'b0};
            end
        end
        if (state_reg == ST_READ)
            old_reg <= ring[addr];
        if (state_reg == ST_UPDATE)
            ring[addr] <= root_reg;
        if (div_done)
            mean_reg <= (count_reg[k_reg] == '0) ? '0 : DIST_W'(quot);
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while accepting points");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(mean_distance)))
        else $error("stalled mean changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sector_empty) |-> (mean_distance == '0))
        else $error("empty sector with nonzero mean");
`endif
endmodule
